// ===== rtl/gaussian_s_curve_contrast_core_macros.svh =====
// Assertion macros shared by the gaussian S-curve contrast RTL.
`ifndef GAUSSIAN_S_CURVE_CONTRAST_CORE_MACROS_SVH
`define GAUSSIAN_S_CURVE_CONTRAST_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define GSCC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define GSCC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/gscc_pkg.sv =====
// Shared widths, constants, types and helpers of the gaussian S-curve contrast core.
package gscc_pkg;

    localparam int PIX_W      = 8;
    localparam int GAIN_W     = 13;
    localparam int CENTER_W   = 9;
    localparam int SIGMA_W    = 8;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int DIFF_W     = 11;
    localparam int VMAG_W     = 9;
    localparam int GMAG_W     = 13;
    localparam int S2_W       = 16;
    localparam int VSQ_W      = 18;
    localparam int DVS_W      = 22;
    localparam int GV_W       = 22;
    localparam int FRAC_W     = 30;
    localparam int U_W        = 30;
    localparam int TERM_W     = 31;
    localparam int SUM_W      = 32;
    localparam int MAG_W      = 53;
    localparam int TOTAL_W    = 55;
    localparam int OUT_SHIFT  = 38;
    localparam int NUM_TERMS  = 13;
    localparam int DIV_STAGES = U_W / 2;
    localparam int SQUARINGS  = 5;

    localparam logic [TERM_W-1:0] ONE_Q30 = TERM_W'(1) << FRAC_W;

    localparam logic signed [GAIN_W-1:0]   GAIN_RESET   = 13'sd256;
    localparam logic signed [CENTER_W-1:0] CENTER_RESET = 9'sd0;
    localparam logic [SIGMA_W-1:0]         SIGMA_RESET  = 8'd30;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN   = 2'd0,
        REG_CENTER = 2'd1,
        REG_SIGMA  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic             apply;
        logic             neg;
        logic [GV_W-1:0]  gv;
        logic [PIX_W-1:0] x;
        logic             fe;
    } side_t;

    function automatic logic [DVS_W:0] div_step(input logic [DVS_W-1:0] rem,
                                                input logic [DVS_W-1:0] dvs);
        logic [DVS_W:0] dbl;
        logic [DVS_W:0] diff;
        dbl  = {rem, 1'b0};
        diff = dbl - {1'b0, dvs};
        if (dbl >= {1'b0, dvs}) begin
            return {1'b1, diff[DVS_W-1:0]};
        end
        return {1'b0, dbl[DVS_W-1:0]};
    endfunction

endpackage

// ===== rtl/gscc_div.sv =====
// Pipelined restoring divider: u = (vsq << 30) / dvs, two quotient bits per stage.
`include "gaussian_s_curve_contrast_core_macros.svh"

module gscc_div
    import gscc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [VSQ_W-1:0] vsq,
    input  logic [DVS_W-1:0] dvs,
    input  side_t            in_side,
    output logic             out_valid,
    output logic [U_W-1:0]   u,
    output side_t            out_side
);

    logic             valid_reg [DIV_STAGES];
    logic [DVS_W-1:0] rem_reg   [DIV_STAGES];
    logic [U_W-1:0]   quo_reg   [DIV_STAGES];
    logic [DVS_W-1:0] dvs_reg   [DIV_STAGES];
    side_t            side_reg  [DIV_STAGES];

    logic             valid_next [DIV_STAGES];
    logic [DVS_W-1:0] rem_next   [DIV_STAGES];
    logic [U_W-1:0]   quo_next   [DIV_STAGES];
    logic [DVS_W-1:0] dvs_next   [DIV_STAGES];
    side_t            side_next  [DIV_STAGES];

    always_comb begin
        logic             v_in;
        logic [DVS_W-1:0] r_in;
        logic [U_W-1:0]   q_in;
        logic [DVS_W-1:0] d_in;
        side_t            s_in;
        logic [DVS_W:0]   st1;
        logic [DVS_W:0]   st2;
        for (int j = 0; j < DIV_STAGES; j++) begin
            if (j == 0) begin
                v_in       = in_valid;
                r_in       = DVS_W'(vsq);
                q_in       = '0;
                d_in       = dvs;
                s_in       = in_side;
                s_in.apply = in_side.apply & (DVS_W'(vsq) < dvs);
            end else begin
                v_in = valid_reg[j-1];
                r_in = rem_reg[j-1];
                q_in = quo_reg[j-1];
                d_in = dvs_reg[j-1];
                s_in = side_reg[j-1];
            end
            st1           = div_step(r_in, d_in);
            st2           = div_step(st1[DVS_W-1:0], d_in);
            valid_next[j] = v_in;
            rem_next[j]   = st2[DVS_W-1:0];
            quo_next[j]   = {q_in[U_W-3:0], st1[DVS_W], st2[DVS_W]};
            dvs_next[j]   = d_in;
            side_next[j]  = s_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < DIV_STAGES; j++) begin
                valid_reg[j] <= 1'b0;
            end
        end else if (en) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            dvs_reg  <= dvs_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign u         = quo_reg[DIV_STAGES-1];
    assign out_side  = side_reg[DIV_STAGES-1];

    `GSCC_ASSERT_IMP(a_rem_below_dvs, aclk, aresetn,
        valid_reg[DIV_STAGES-1] && side_reg[DIV_STAGES-1].apply,
        rem_reg[DIV_STAGES-1] < dvs_reg[DIV_STAGES-1],
        "divider remainder not below divisor")

endmodule

// ===== rtl/gscc_term.sv =====
// One Taylor term of exp(-u): term = ((term * u) >> 30) / K, added to or taken from the sum.
module gscc_term
    import gscc_pkg::*;
#(
    parameter int unsigned K = 1
)
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [TERM_W-1:0]        in_term,
    input  logic signed [SUM_W-1:0]  in_sum,
    input  logic [U_W-1:0]           in_u,
    input  side_t                    in_side,
    output logic                     out_valid,
    output logic [TERM_W-1:0]        out_term,
    output logic signed [SUM_W-1:0]  out_sum,
    output logic [U_W-1:0]           out_u,
    output side_t                    out_side
);

    localparam logic [31:0]    RECIP = 32'(64'hFFFF_FFFF / K);
    localparam logic [U_W-1:0] KC    = U_W'(K);
    localparam bit             ODD   = (K % 2) == 1;

    logic                    v1_reg, v2_reg, v3_reg;
    logic [U_W-1:0]          p1_reg, p2_reg, est2_reg, q3_reg;
    logic [U_W-1:0]          u1_reg, u2_reg, u3_reg;
    logic signed [SUM_W-1:0] sum1_reg, sum2_reg, sum3_reg;
    side_t                   side1_reg, side2_reg, side3_reg;

    logic [TERM_W+U_W-1:0]   prod1;
    logic [U_W+31:0]         prod2;
    logic [U_W-1:0]          p1_next, est2_next, chk, q3_next;
    logic signed [SUM_W-1:0] sum3_next;

    always_comb begin
        prod1     = (TERM_W+U_W)'(in_term) * (TERM_W+U_W)'(in_u);
        p1_next   = prod1[FRAC_W+U_W-1:FRAC_W];
        prod2     = (U_W+32)'(p1_reg) * (U_W+32)'(RECIP);
        est2_next = prod2[U_W+31:32];
        chk       = p2_reg - est2_reg * KC;
        q3_next   = (chk >= KC) ? est2_reg + U_W'(1) : est2_reg;
        sum3_next = ODD ? sum2_reg - $signed(SUM_W'(q3_next))
                        : sum2_reg + $signed(SUM_W'(q3_next));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg    <= p1_next;
            u1_reg    <= in_u;
            sum1_reg  <= in_sum;
            side1_reg <= in_side;
            p2_reg    <= p1_reg;
            est2_reg  <= est2_next;
            u2_reg    <= u1_reg;
            sum2_reg  <= sum1_reg;
            side2_reg <= side1_reg;
            q3_reg    <= q3_next;
            u3_reg    <= u2_reg;
            sum3_reg  <= sum3_next;
            side3_reg <= side2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_term  = TERM_W'(q3_reg);
    assign out_sum   = sum3_reg;
    assign out_u     = u3_reg;
    assign out_side  = side3_reg;

endmodule

// ===== rtl/gscc_tail.sv =====
// Clamp and square the series five times, scale by gain and offset, then round and saturate.
`include "gaussian_s_curve_contrast_core_macros.svh"

module gscc_tail
    import gscc_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [SUM_W-1:0] in_sum,
    input  side_t                   in_side,
    output logic                    out_valid,
    output logic [PIX_W-1:0]        pixel,
    output logic                    fe
);

    logic              sq_valid_reg [SQUARINGS];
    logic [TERM_W-1:0] sq_e_reg     [SQUARINGS];
    side_t             sq_side_reg  [SQUARINGS];
    logic              sq_valid_next [SQUARINGS];
    logic [TERM_W-1:0] sq_e_next     [SQUARINGS];
    side_t             sq_side_next  [SQUARINGS];

    logic               mul_valid_reg, out_valid_reg;
    logic [MAG_W-1:0]   mag_reg;
    side_t              mul_side_reg;
    logic [PIX_W-1:0]   pixel_reg;
    logic               fe_reg;

    logic [TERM_W-1:0]  e0;
    logic [MAG_W-1:0]   mag_next;
    logic signed [TOTAL_W-1:0] base, total, rnd;
    logic [TOTAL_W-OUT_SHIFT-1:0] hi;
    logic [PIX_W-1:0]   pixel_next;

    always_comb begin
        if (in_sum < 0) begin
            e0 = '0;
        end else if (in_sum > $signed(SUM_W'(ONE_Q30))) begin
            e0 = ONE_Q30;
        end else begin
            e0 = TERM_W'(in_sum);
        end
    end

    always_comb begin
        logic              v_in;
        logic [TERM_W-1:0] e_in;
        side_t             s_in;
        logic [2*TERM_W-1:0] prod;
        for (int j = 0; j < SQUARINGS; j++) begin
            if (j == 0) begin
                v_in = in_valid;
                e_in = e0;
                s_in = in_side;
            end else begin
                v_in = sq_valid_reg[j-1];
                e_in = sq_e_reg[j-1];
                s_in = sq_side_reg[j-1];
            end
            prod             = (2*TERM_W)'(e_in) * (2*TERM_W)'(e_in);
            sq_valid_next[j] = v_in;
            sq_e_next[j]     = prod[FRAC_W+TERM_W-1:FRAC_W];
            sq_side_next[j]  = s_in;
        end
    end

    always_comb begin
        mag_next = MAG_W'(sq_side_reg[SQUARINGS-1].gv) * MAG_W'(sq_e_reg[SQUARINGS-1]);
        base     = $signed(TOTAL_W'(mul_side_reg.x) << OUT_SHIFT);
        if (!mul_side_reg.apply) begin
            total = base;
        end else if (mul_side_reg.neg) begin
            total = base - $signed(TOTAL_W'(mag_reg));
        end else begin
            total = base + $signed(TOTAL_W'(mag_reg));
        end
        rnd = total + $signed(TOTAL_W'(1) << (OUT_SHIFT - 1));
        hi  = rnd[TOTAL_W-1:OUT_SHIFT];
        if (total[TOTAL_W-1]) begin
            pixel_next = '0;
        end else if (|hi[TOTAL_W-OUT_SHIFT-1:PIX_W]) begin
            pixel_next = '1;
        end else begin
            pixel_next = hi[PIX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < SQUARINGS; j++) begin
                sq_valid_reg[j] <= 1'b0;
            end
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            sq_valid_reg  <= sq_valid_next;
            mul_valid_reg <= sq_valid_reg[SQUARINGS-1];
            out_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_e_reg     <= sq_e_next;
            sq_side_reg  <= sq_side_next;
            mag_reg      <= mag_next;
            mul_side_reg <= sq_side_reg[SQUARINGS-1];
            pixel_reg    <= pixel_next;
            fe_reg       <= mul_side_reg.fe;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel     = pixel_reg;
    assign fe        = fe_reg;

    `GSCC_ASSERT_IMP(a_gauss_bounded, aclk, aresetn,
        sq_valid_reg[SQUARINGS-1],
        sq_e_reg[SQUARINGS-1] <= ONE_Q30,
        "gaussian weight above one")

endmodule

// ===== rtl/gaussian_s_curve_contrast_core.sv =====
// Top level of the gaussian S-curve contrast core: config, front stages, pipeline, output skid.
//
// Usage:
//   Input stream s_*: one 8-bit sample per request in s_tdata, frame end on s_tlast.
//   Output stream m_*: the tone-mapped sample in m_tdata, the frame end copied to m_tlast.
//   cfg_*: write gain (index 0, signed Q5.8), center (index 1, signed levels) and
//   sigma (index 2, levels) while no request is in flight; other indexes are dropped.
//   Pipeline: a sample accepted on s_* passes 63 register stages before it appears on m_*
//   (2 front stages, 15 divider stages of two quotient bits, 13 series terms of 3 stages,
//   5 squaring stages, scale and round).
//   Throughput: one sample per cycle while the skid is empty, set by the fully pipelined
//   divider and multiplier stages; samples enter back to back with no gaps.
//   Stall: when m_tready is low, the result in the last stage moves to a one-entry
//   skid register and the pipeline still advances on that edge; while the skid holds
//   a result, s_tready is low and all stages hold. Nothing is dropped or repeated.
//   Reset (aresetn low at a clock edge): all valid bits and the skid clear and the
//   registers return to gain 1.0, center 0, sigma 30.
`include "gaussian_s_curve_contrast_core_macros.svh"

module gaussian_s_curve_contrast_core
    import gscc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] pixel_in
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [7:0] pixel_out
    output logic                 m_tlast
);

    logic signed [GAIN_W-1:0]   gain_reg;
    logic signed [CENTER_W-1:0] center_reg;
    logic [SIGMA_W-1:0]         sigma_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg   <= GAIN_RESET;
            center_reg <= CENTER_RESET;
            sigma_reg  <= SIGMA_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_GAIN:   gain_reg   <= cfg_data[GAIN_W-1:0];
                REG_CENTER: center_reg <= cfg_data[CENTER_W-1:0];
                REG_SIGMA:  sigma_reg  <= cfg_data[SIGMA_W-1:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic skid_valid_reg;
    logic [PIX_W-1:0] skid_pixel_reg;
    logic skid_fe_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // front stage A: difference, magnitudes, sigma squared
    logic              a_valid_reg;
    logic [PIX_W-1:0]  a_x_reg;
    logic              a_fe_reg;
    logic [VMAG_W-1:0] a_vmag_reg;
    logic [GMAG_W-1:0] a_gmag_reg;
    logic              a_neg_reg;
    logic [S2_W-1:0]   a_s2_reg;

    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        diff_abs;
    logic [GMAG_W-1:0]        gain_abs;

    always_comb begin
        diff     = $signed({3'b000, s_tdata[PIX_W-1:0]})
                 - $signed({{(DIFF_W-CENTER_W){center_reg[CENTER_W-1]}}, center_reg});
        diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        gain_abs = gain_reg[GAIN_W-1] ? GMAG_W'(-gain_reg) : GMAG_W'(gain_reg);
    end

    // front stage B: squares, divisor, gain times distance
    logic             b_valid_reg;
    logic [VSQ_W-1:0] b_vsq_reg;
    logic [DVS_W-1:0] b_dvs_reg;
    side_t            b_side_reg;
    side_t            b_side_next;

    always_comb begin
        b_side_next.apply = (a_s2_reg != '0) && (a_vmag_reg != '0) && (a_gmag_reg != '0);
        b_side_next.neg   = a_neg_reg;
        b_side_next.gv    = GV_W'(a_gmag_reg) * GV_W'(a_vmag_reg);
        b_side_next.x     = a_x_reg;
        b_side_next.fe    = a_fe_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= s_tvalid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_x_reg    <= s_tdata[PIX_W-1:0];
            a_fe_reg   <= s_tlast;
            a_vmag_reg <= diff_abs[VMAG_W-1:0];
            a_gmag_reg <= gain_abs;
            a_neg_reg  <= gain_reg[GAIN_W-1] ^ diff[DIFF_W-1];
            a_s2_reg   <= S2_W'(sigma_reg) * S2_W'(sigma_reg);
            b_vsq_reg  <= VSQ_W'(a_vmag_reg) * VSQ_W'(a_vmag_reg);
            b_dvs_reg  <= {a_s2_reg, 6'b000000};
            b_side_reg <= b_side_next;
        end
    end

    logic           div_valid;
    logic [U_W-1:0] div_u;
    side_t          div_side;

    gscc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (b_valid_reg),
        .vsq       (b_vsq_reg),
        .dvs       (b_dvs_reg),
        .in_side   (b_side_reg),
        .out_valid (div_valid),
        .u         (div_u),
        .out_side  (div_side)
    );

    logic                    t_valid [NUM_TERMS+1];
    logic [TERM_W-1:0]       t_term  [NUM_TERMS+1];
    logic signed [SUM_W-1:0] t_sum   [NUM_TERMS+1];
    logic [U_W-1:0]          t_u     [NUM_TERMS+1];
    side_t                   t_side  [NUM_TERMS+1];

    assign t_valid[0] = div_valid;
    assign t_term[0]  = ONE_Q30;
    assign t_sum[0]   = $signed(SUM_W'(ONE_Q30));
    assign t_u[0]     = div_u;
    assign t_side[0]  = div_side;

    for (genvar k = 0; k < NUM_TERMS; k++) begin : g_term
        gscc_term #(
            .K (k + 1)
        ) u_term (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (t_valid[k]),
            .in_term   (t_term[k]),
            .in_sum    (t_sum[k]),
            .in_u      (t_u[k]),
            .in_side   (t_side[k]),
            .out_valid (t_valid[k+1]),
            .out_term  (t_term[k+1]),
            .out_sum   (t_sum[k+1]),
            .out_u     (t_u[k+1]),
            .out_side  (t_side[k+1])
        );
    end

    logic             tail_valid;
    logic [PIX_W-1:0] tail_pixel;
    logic             tail_fe;

    gscc_tail u_tail (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (t_valid[NUM_TERMS]),
        .in_sum    (t_sum[NUM_TERMS]),
        .in_side   (t_side[NUM_TERMS]),
        .out_valid (tail_valid),
        .pixel     (tail_pixel),
        .fe        (tail_fe)
    );

    // output skid: catch the last stage when the receiver stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (tail_valid && !m_tready) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!skid_valid_reg && tail_valid && !m_tready) begin
            skid_pixel_reg <= tail_pixel;
            skid_fe_reg    <= tail_fe;
        end
    end

    assign m_tvalid = skid_valid_reg | tail_valid;
    assign m_tdata  = skid_valid_reg ? skid_pixel_reg : tail_pixel;
    assign m_tlast  = skid_valid_reg ? skid_fe_reg : tail_fe;

    `GSCC_ASSERT_NXT(a_hold_while_skid, aclk, aresetn,
        skid_valid_reg,
        $stable(tail_pixel) && $stable(tail_fe) && $stable(tail_valid),
        "last stage moved while skid was full")
    `GSCC_ASSERT_IMP(a_skid_fill, aclk, aresetn,
        $rose(skid_valid_reg),
        $past(tail_valid) && !$past(m_tready),
        "skid filled without a stalled result")
    `GSCC_ASSERT_NXT(a_skid_drain, aclk, aresetn,
        skid_valid_reg && m_tready,
        !skid_valid_reg,
        "skid kept a result after it was taken")

endmodule
